@@ rtl/core/dssp_pkg.sv @@
// ----------------------------------------------------------------------------
// dssp_pkg
// Types, constants and helpers shared by the dual servo slew limiter.
// ----------------------------------------------------------------------------
package dssp_pkg;

    localparam int ANGLE_W     = 9;
    localparam int TARGET_W    = 10;
    localparam int SEL_W       = 2;
    localparam int CMP_W       = 22;
    localparam int MIN_PULSE_W = 12;
    localparam int SENS_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;

    // min_pulse * 25 and sensitivity * 25, held pre-scaled
    localparam int MP25_W   = 17;
    localparam int SENS25_W = 13;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX  = '1;
    localparam logic [ANGLE_W-1:0] STEP_DEG   = ANGLE_W'(2);
    localparam logic [ANGLE_W-1:0] HOME_ANGLE = ANGLE_W'(90);

    localparam logic [ANGLE_W-1:0]     MIN_ANGLE_RST   = ANGLE_W'(0);
    localparam logic [ANGLE_W-1:0]     MAX_ANGLE_RST   = ANGLE_W'(180);
    localparam logic [MIN_PULSE_W-1:0] MIN_PULSE_RST   = MIN_PULSE_W'(100);
    localparam logic [SENS_W-1:0]      SENSITIVITY_RST = SENS_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_ANGLE   = 2'd0,
        REG_MAX_ANGLE   = 2'd1,
        REG_MIN_PULSE   = 2'd2,
        REG_SENSITIVITY = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_MOVE = 1'b1
    } action_t;

    localparam logic [SEL_W-1:0] SEL_ONE = SEL_W'(1);
    localparam logic [SEL_W-1:0] SEL_TWO = SEL_W'(2);

    typedef struct packed {
        logic               moved;
        logic [ANGLE_W-1:0] angle;
    } slew_res_t;

    // x * 25 as x*16 + x*8 + x
    function automatic logic [MP25_W-1:0] times25_pulse(input logic [MIN_PULSE_W-1:0] x);
        logic [MP25_W-1:0] xe;
        xe = MP25_W'(x);
        return (xe << 4) + (xe << 3) + xe;
    endfunction

    function automatic logic [SENS25_W-1:0] times25_sens(input logic [SENS_W-1:0] x);
        logic [SENS25_W-1:0] xe;
        xe = SENS25_W'(x);
        return (xe << 4) + (xe << 3) + xe;
    endfunction

endpackage

@@ rtl/core/dssp_slew.sv @@
// ----------------------------------------------------------------------------
// dssp_slew
// One channel's slew step: move the angle 2 degrees toward the goal.
// ----------------------------------------------------------------------------
module dssp_slew (
    input  logic [dssp_pkg::ANGLE_W-1:0] angle_now,
    input  logic [dssp_pkg::ANGLE_W-1:0] angle_goal,
    output dssp_pkg::slew_res_t          res
);
    import dssp_pkg::*;

    logic [ANGLE_W:0] up_sum;

    assign up_sum = {1'b0, angle_now} + {1'b0, STEP_DEG};

    always_comb begin
        res.moved = (angle_now != angle_goal);
        if (angle_now < angle_goal) begin
            // saturate at the top of the angle range
            res.angle = up_sum[ANGLE_W] ? ANGLE_MAX : up_sum[ANGLE_W-1:0];
        end else if (angle_now > angle_goal) begin
            // saturate at zero
            res.angle = (angle_now < STEP_DEG) ? '0 : angle_now - STEP_DEG;
        end else begin
            res.angle = angle_now;
        end
    end

endmodule

@@ rtl/core/dssp_pulse.sv @@
// ----------------------------------------------------------------------------
// dssp_pulse
// PWM compare for one angle: (min_pulse + (angle - min_angle) * sens) * 25.
// ----------------------------------------------------------------------------
module dssp_pulse (
    input  logic [dssp_pkg::ANGLE_W-1:0]  angle,
    input  logic [dssp_pkg::ANGLE_W-1:0]  min_angle,
    input  logic [dssp_pkg::MP25_W-1:0]   min_pulse25,
    input  logic [dssp_pkg::SENS25_W-1:0] sens25,
    output logic [dssp_pkg::CMP_W-1:0]    compare
);
    import dssp_pkg::*;

    localparam int DIFF_W = ANGLE_W + 1;
    localparam int PROD_W = DIFF_W + SENS25_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [SENS25_W:0]   sens_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SUM_W-1:0]    on_time;

    // scale folded into the pre-scaled config, so one multiply remains
    assign diff    = $signed({1'b0, angle}) - $signed({1'b0, min_angle});
    assign sens_s  = $signed({1'b0, sens25});
    assign prod    = PROD_W'(diff) * PROD_W'(sens_s);
    assign on_time = SUM_W'(prod) + $signed(SUM_W'({1'b0, min_pulse25}));

    // clamp a negative on-time to zero
    assign compare = on_time[SUM_W-1] ? '0 : on_time[CMP_W-1:0];

endmodule

@@ rtl/core/dual_servo_slew_pwm.sv @@
// ----------------------------------------------------------------------------
// dual_servo_slew_pwm
// Two-channel servo slew limiter with PWM compare generation.
// ----------------------------------------------------------------------------
// Every input word produces exactly one result word. A move word (action 1)
// on channel 1 or 2 rounds the target down to even, clamps it to the angle
// limits, stores it as that channel's goal and sets busy; other channel
// numbers are dropped without effect except for the result word. A tick word
// (action 0) steps each channel 2 degrees toward its goal and rewrites the
// compare of each channel that moved. The block takes one word per cycle
// while m_ready stays high: the input register feeds the slew step, a
// middle register holds the new angles, and the compare multiply sits
// between it and the output register. Configuration writes are registered;
// min_pulse and sensitivity are stored pre-multiplied by 25. Write
// configuration only while no word is in flight.
// ----------------------------------------------------------------------------
module dual_servo_slew_pwm (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [dssp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dssp_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [dssp_pkg::SEL_W-1:0]          s_servo_sel,
    input  logic signed [dssp_pkg::TARGET_W-1:0] s_target_angle,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dssp_pkg::CMP_W-1:0]          m_pulse_one,
    output logic [dssp_pkg::CMP_W-1:0]          m_pulse_two,
    output logic                                m_update_one,
    output logic                                m_update_two,
    output logic                                m_busy_res
);
    import dssp_pkg::*;

    // ---------------- configuration ----------------
    logic [ANGLE_W-1:0]  min_angle_reg;
    logic [ANGLE_W-1:0]  max_angle_reg;
    logic [MP25_W-1:0]   min_pulse25_reg;
    logic [SENS25_W-1:0] sens25_reg;

    // Hold each register until its index is written; pre-scale the pulse terms.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_angle_reg   <= MIN_ANGLE_RST;
            max_angle_reg   <= MAX_ANGLE_RST;
            min_pulse25_reg <= times25_pulse(MIN_PULSE_RST);
            sens25_reg      <= times25_sens(SENSITIVITY_RST);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_ANGLE:   min_angle_reg   <= cfg_wdata[ANGLE_W-1:0];
                REG_MAX_ANGLE:   max_angle_reg   <= cfg_wdata[ANGLE_W-1:0];
                REG_MIN_PULSE:   min_pulse25_reg <= times25_pulse(cfg_wdata[MIN_PULSE_W-1:0]);
                REG_SENSITIVITY: sens25_reg      <= times25_sens(cfg_wdata[SENS_W-1:0]);
                default: ;
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic in_vld_reg, mid_vld_reg, out_vld_reg;
    logic out_load, mid_load, in_load;
    logic mid_move, in_move;

    // A stage loads when it is empty or its word moves on this cycle.
    assign out_load = !out_vld_reg || m_ready;
    assign mid_move = mid_vld_reg && out_load;
    assign mid_load = !mid_vld_reg || out_load;
    assign in_move  = in_vld_reg && mid_load;
    assign in_load  = !in_vld_reg || mid_load;
    assign s_ready  = in_load;

    // ---------------- stage 1: input register ----------------
    logic                       action_reg;
    logic [SEL_W-1:0]           sel_reg;
    logic signed [TARGET_W-1:0] target_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_load) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load && s_valid) begin
            action_reg <= s_action;
            sel_reg    <= s_servo_sel;
            target_reg <= s_target_angle;
        end
    end

    // ---------------- slew and goal update ----------------
    logic [ANGLE_W-1:0] now_one_reg, goal_one_reg, now_two_reg, goal_two_reg;
    logic [ANGLE_W-1:0] now_one_next, goal_one_next, now_two_next, goal_two_next;
    logic               busy_reg, busy_next;
    slew_res_t          slew_one, slew_two;

    dssp_slew u_slew_one (
        .angle_now  (now_one_reg),
        .angle_goal (goal_one_reg),
        .res        (slew_one)
    );

    dssp_slew u_slew_two (
        .angle_now  (now_two_reg),
        .angle_goal (goal_two_reg),
        .res        (slew_two)
    );

    // Round the target down to even, then clamp it: the lower limit wins.
    logic signed [TARGET_W:0] target_even;
    logic [ANGLE_W-1:0]       goal_clamped;
    logic                     sel_valid;
    logic                     is_move;
    logic                     upd_one, upd_two;

    assign target_even = {target_reg[TARGET_W-1], target_reg[TARGET_W-1:1], 1'b0};
    assign sel_valid   = (sel_reg == SEL_ONE) || (sel_reg == SEL_TWO);
    assign is_move     = (action_t'(action_reg) == ACT_MOVE);

    always_comb begin
        priority if (target_even < $signed({2'b00, min_angle_reg})) begin
            goal_clamped = min_angle_reg;
        end else if (target_even > $signed({2'b00, max_angle_reg})) begin
            goal_clamped = max_angle_reg;
        end else begin
            goal_clamped = target_even[ANGLE_W-1:0];
        end
    end

    always_comb begin
        now_one_next  = now_one_reg;
        now_two_next  = now_two_reg;
        goal_one_next = goal_one_reg;
        goal_two_next = goal_two_reg;
        busy_next     = busy_reg;
        upd_one       = 1'b0;
        upd_two       = 1'b0;
        if (is_move) begin
            if (sel_reg == SEL_ONE) begin
                goal_one_next = goal_clamped;
            end
            if (sel_reg == SEL_TWO) begin
                goal_two_next = goal_clamped;
            end
            if (sel_valid) begin
                busy_next = 1'b1;
            end
        end else begin
            upd_one      = slew_one.moved;
            upd_two      = slew_two.moved;
            now_one_next = slew_one.angle;
            now_two_next = slew_two.angle;
            if (!slew_one.moved && !slew_two.moved) begin
                busy_next = 1'b0;
            end
        end
    end

    // Advance channel state as each word leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_one_reg  <= HOME_ANGLE;
            goal_one_reg <= HOME_ANGLE;
            now_two_reg  <= HOME_ANGLE;
            goal_two_reg <= HOME_ANGLE;
            busy_reg     <= 1'b0;
        end else if (in_move) begin
            now_one_reg  <= now_one_next;
            goal_one_reg <= goal_one_next;
            now_two_reg  <= now_two_next;
            goal_two_reg <= goal_two_next;
            busy_reg     <= busy_next;
        end
    end

    // ---------------- stage 2: middle register ----------------
    logic               mid_upd_one_reg, mid_upd_two_reg, mid_busy_reg;
    logic [ANGLE_W-1:0] mid_ang_one_reg, mid_ang_two_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_vld_reg <= 1'b0;
        end else if (mid_load) begin
            mid_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_move) begin
            mid_upd_one_reg <= upd_one;
            mid_upd_two_reg <= upd_two;
            mid_busy_reg    <= busy_next;
            mid_ang_one_reg <= now_one_next;
            mid_ang_two_reg <= now_two_next;
        end
    end

    // ---------------- compare computation ----------------
    logic [CMP_W-1:0] cmp_one_new, cmp_two_new;
    logic [CMP_W-1:0] compare_one_reg, compare_two_reg;
    logic [CMP_W-1:0] compare_one_next, compare_two_next;

    dssp_pulse u_pulse_one (
        .angle       (mid_ang_one_reg),
        .min_angle   (min_angle_reg),
        .min_pulse25 (min_pulse25_reg),
        .sens25      (sens25_reg),
        .compare     (cmp_one_new)
    );

    dssp_pulse u_pulse_two (
        .angle       (mid_ang_two_reg),
        .min_angle   (min_angle_reg),
        .min_pulse25 (min_pulse25_reg),
        .sens25      (sens25_reg),
        .compare     (cmp_two_new)
    );

    // Keep the old compare unless this word moved the channel.
    assign compare_one_next = mid_upd_one_reg ? cmp_one_new : compare_one_reg;
    assign compare_two_next = mid_upd_two_reg ? cmp_two_new : compare_two_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compare_one_reg <= '0;
            compare_two_reg <= '0;
        end else if (mid_move) begin
            compare_one_reg <= compare_one_next;
            compare_two_reg <= compare_two_next;
        end
    end

    // ---------------- stage 3: output register ----------------
    logic [CMP_W-1:0] out_pulse_one_reg, out_pulse_two_reg;
    logic             out_upd_one_reg, out_upd_two_reg, out_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_load) begin
            out_vld_reg <= mid_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_move) begin
            out_pulse_one_reg <= compare_one_next;
            out_pulse_two_reg <= compare_two_next;
            out_upd_one_reg   <= mid_upd_one_reg;
            out_upd_two_reg   <= mid_upd_two_reg;
            out_busy_reg      <= mid_busy_reg;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_pulse_one  = out_pulse_one_reg;
    assign m_pulse_two  = out_pulse_two_reg;
    assign m_update_one = out_upd_one_reg;
    assign m_update_two = out_upd_two_reg;
    assign m_busy_res   = out_busy_reg;

    // ---------------- assertions ----------------
    // A channel that moved means a move is still settling.
    a_update_implies_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_update_one || m_update_two) |-> m_busy_res)
        else $error("update reported without busy");

    // Idle means both channels sit on their goals.
    a_idle_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (now_one_reg == goal_one_reg) && (now_two_reg == goal_two_reg))
        else $error("busy clear while a channel is off its goal");

    // Backpressure only when every stage holds a word.
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_vld_reg && mid_vld_reg && out_vld_reg)
        else $error("input stalled with a free stage");

endmodule
